>>> design/conv2d_bias_activation_unit_defines.svh
// Assertion macros for the convolution unit.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef CONV2D_BIAS_ACTIVATION_UNIT_DEFINES_SVH
`define CONV2D_BIAS_ACTIVATION_UNIT_DEFINES_SVH

// same-cycle implication
`define CBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/cba_pkg.sv
// Shared types, codes and helper functions of the convolution unit.
// No dependencies.
package cba_pkg;

  typedef struct packed {
    logic [1:0]         operation;
    logic [2:0]         filter_index;
    logic [1:0]         channel_index;
    logic [2:0]         tap_row;
    logic [2:0]         tap_col;
    logic signed [15:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         out_filter;
    logic [8:0]         out_row;
    logic [8:0]         out_col;
    logic signed [15:0] out_value;
    logic               last;
  } out_word_t;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_PIXEL  = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [1:0] PAD_SAME = 2'd1;
  localparam logic [1:0] PAD_FULL = 2'd2;

  localparam logic [1:0] ACT_RELU    = 2'd1;
  localparam logic [1:0] ACT_SIGMOID = 2'd2;

  localparam logic [2:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_KERN_W     = 3'd2;
  localparam logic [2:0] REG_KERN_H     = 3'd3;
  localparam logic [2:0] REG_PAD_MODE   = 3'd4;
  localparam logic [2:0] REG_ACT_MODE   = 3'd5;
  localparam logic [2:0] REG_CHANNELS   = 3'd6;
  localparam logic [2:0] REG_KERNELS    = 3'd7;

  // sigmoid at steps of 0.5, Q8.8
  function automatic logic [8:0] sig_tab(input logic [4:0] idx);
    logic [8:0] y;
    unique case (idx)
      5'd0:  y = 9'd128;
      5'd1:  y = 9'd159;
      5'd2:  y = 9'd187;
      5'd3:  y = 9'd209;
      5'd4:  y = 9'd225;
      5'd5:  y = 9'd237;
      5'd6:  y = 9'd244;
      5'd7:  y = 9'd248;
      5'd8:  y = 9'd251;
      5'd9:  y = 9'd253;
      5'd10: y = 9'd254;
      5'd11: y = 9'd255;
      5'd12: y = 9'd255;
      default: y = 9'd256;
    endcase
    return y;
  endfunction

  function automatic logic signed [15:0] sigmoid_q88(input logic signed [15:0] x);
    logic [16:0] a;
    logic [3:0]  i;
    logic [6:0]  fr;
    logic [8:0]  t0;
    logic [8:0]  t1;
    logic [5:0]  dlt;
    logic [13:0] pr;
    logic [8:0]  y;
    a   = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
    i   = a[10:7];
    fr  = a[6:0];
    t0  = sig_tab({1'b0, i});
    t1  = sig_tab({1'b0, i} + 5'd1);
    dlt = 6'(t1 - t0);
    pr  = ({8'd0, dlt} * {7'd0, fr}) + 14'd64;
    y   = (a >= 17'd2048) ? 9'd256 : (t0 + 9'(pr >> 7));
    return x[15] ? (16'sd256 - $signed({7'd0, y})) : $signed({7'd0, y});
  endfunction

endpackage

>>> design/cba_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module cba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/cba_cell.sv
// One window cell: holds a sample, rotates to its ring neighbor or loads.
// No dependencies.
module cba_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rot_i,
  input  logic signed [15:0] nbr_i,
  input  logic               upd_i,
  input  logic signed [15:0] upd_val_i,
  output logic signed [15:0] val_o
);

  logic signed [15:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (rot_i) begin
      val_d = nbr_i;
    end else if (upd_i) begin
      val_d = upd_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

>>> design/cba_window.sv
// Window of MAX_KERNEL x MAX_KERNEL x MAX_CHANNELS cells, wired as a ring.
// Depends on cba_cell.
module cba_window #(
  parameter int MAX_KERNEL   = 5,
  parameter int MAX_CHANNELS = 4,
  localparam int KBW = $clog2(MAX_KERNEL + 1),
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int LR  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rot_i,
  input  logic               upd_i,
  input  logic [CHW-1:0]     ch_i,
  input  logic [KBW-1:0]     kw_i,
  input  logic [KBW-1:0]     kh_i,
  input  logic [LR*16-1:0]   line_i,
  input  logic signed [15:0] pix_i,
  output logic signed [15:0] head_o
);

  localparam int N = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;

  logic signed [15:0] vals [N];
  logic signed [15:0] uval [N];
  logic signed [15:0] tail [N];
  logic               sel  [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int R = i / (MAX_KERNEL * MAX_CHANNELS);
    localparam int C = (i / MAX_CHANNELS) % MAX_KERNEL;
    localparam int K = i % MAX_CHANNELS;
    localparam int NX = (i + 1) % N;

    assign sel[i] = upd_i && (CHW'(K) == ch_i) && (KBW'(R) < kh_i) && (KBW'(C) < kw_i);

    // rightmost used column takes the line store row above, bottom row the pixel
    if (R + 1 < MAX_KERNEL) begin : g_line
      assign tail[i] = (KBW'(R + 1) < kh_i) ? $signed(line_i[R*16 +: 16]) : pix_i;
    end else begin : g_pix
      assign tail[i] = pix_i;
    end

    if (C + 1 < MAX_KERNEL) begin : g_shift
      assign uval[i] = (KBW'(C + 1) < kw_i) ? vals[i + MAX_CHANNELS] : tail[i];
    end else begin : g_edge
      assign uval[i] = tail[i];
    end

    cba_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .rot_i     (rot_i),
      .nbr_i     (vals[NX]),
      .upd_i     (sel[i]),
      .upd_val_i (uval[i]),
      .val_o     (vals[i])
    );
  end

  assign head_o = vals[0];

endmodule

>>> design/conv2d_bias_activation_unit.sv
// Convolution unit top level: config port, raster control, MAC sequencer.
// Depends on cba_pkg, cba_ram, cba_window and the assertion macro header.
//
// Weight and bias loads are taken straight from the input word. A pixel
// word passes through a line store read and a window update. When a
// word completes a window position the unit runs one pass per kernel: the
// window ring of MAX_KERNEL*MAX_KERNEL*MAX_CHANNELS cells (100 by default)
// rotates past a single multiplier fed from the weight RAM, one tap per
// cycle, and the pass then drains, rounds and hands over. The single
// multiplier and the ring length set the cost of a pass. After reset a
// clearing pass zeroes the LINE_COLS*MAX_CHANNELS words (1056 by default)
// of the line store, during which no input word is taken; configuration
// writes are taken at any time.
`include "conv2d_bias_activation_unit_defines.svh"

module conv2d_bias_activation_unit #(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_FILTERS  = 8,
  parameter int MAX_KERNEL   = 5,
  parameter int MAX_WIDTH    = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cba_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cba_pkg::out_word_t out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int N         = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
  localparam int LINE_COLS = MAX_WIDTH + 2 * (MAX_KERNEL - 1);
  localparam int LD        = LINE_COLS * MAX_CHANNELS;
  localparam int LR        = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int WD        = MAX_FILTERS * N;
  localparam int CW0       = $clog2(LINE_COLS) + 1;
  localparam int CW        = (CW0 > 10) ? CW0 : 10;
  localparam int KBW       = $clog2(MAX_KERNEL + 1);
  localparam int CHW       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CCW       = $clog2(MAX_CHANNELS + 1);
  localparam int FW        = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int FCW       = $clog2(MAX_FILTERS + 1);
  localparam int SW        = (N > 1) ? $clog2(N) : 1;
  localparam int LAW       = (LD > 1) ? $clog2(LD) : 1;
  localparam int WAW       = (WD > 1) ? $clog2(WD) : 1;
  localparam int AW        = 34 + $clog2(N + 1);
  localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
  localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [5:0] {
    ST_CLR   = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LRD   = 6'b000100,
    ST_MAC   = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e state_q;

  // configuration registers
  logic [8:0] in_width_q, in_height_q;
  logic [2:0] kw_q, kh_q, nch_q;
  logic [1:0] pad_q, act_q;
  logic [3:0] nk_q;

  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q  <= 9'd1;
      in_height_q <= 9'd1;
      kw_q        <= 3'd3;
      kh_q        <= 3'd3;
      pad_q       <= 2'd0;
      act_q       <= 2'd0;
      nch_q       <= 3'd1;
      nk_q        <= 4'd1;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        cba_pkg::REG_IN_WIDTH:  in_width_q  <= pwdata[8:0];
        cba_pkg::REG_IN_HEIGHT: in_height_q <= pwdata[8:0];
        cba_pkg::REG_KERN_W:    kw_q        <= pwdata[2:0];
        cba_pkg::REG_KERN_H:    kh_q        <= pwdata[2:0];
        cba_pkg::REG_PAD_MODE:  pad_q       <= pwdata[1:0];
        cba_pkg::REG_ACT_MODE:  act_q       <= pwdata[1:0];
        cba_pkg::REG_CHANNELS:  nch_q       <= pwdata[2:0];
        cba_pkg::REG_KERNELS:   nk_q        <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      cba_pkg::REG_IN_WIDTH:  prdata = {23'd0, in_width_q};
      cba_pkg::REG_IN_HEIGHT: prdata = {23'd0, in_height_q};
      cba_pkg::REG_KERN_W:    prdata = {29'd0, kw_q};
      cba_pkg::REG_KERN_H:    prdata = {29'd0, kh_q};
      cba_pkg::REG_PAD_MODE:  prdata = {30'd0, pad_q};
      cba_pkg::REG_ACT_MODE:  prdata = {30'd0, act_q};
      cba_pkg::REG_CHANNELS:  prdata = {29'd0, nch_q};
      default:                prdata = {28'd0, nk_q};
    endcase
  end

  // clamped geometry
  logic [CW-1:0]  iw, ih, padw, padh, pw, ph;
  logic [3:0]     kw4, kh4;
  logic [6:0]     nch7, nk7;
  logic [KBW-1:0] kw, kh;
  logic [CCW-1:0] nch;
  logic [FCW-1:0] nk;

  always_comb begin
    iw = (in_width_q == 9'd0) ? CW'(1) :
         ((CW'(in_width_q) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(in_width_q));
    ih = (in_height_q == 9'd0) ? CW'(1) :
         ((CW'(in_height_q) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(in_height_q));
    kw4 = (kw_q == 3'd0) ? 4'd1 : (({1'b0, kw_q} > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL)
                                                                 : {1'b0, kw_q});
    kh4 = (kh_q == 3'd0) ? 4'd1 : (({1'b0, kh_q} > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL)
                                                                 : {1'b0, kh_q});
    nch7 = (nch_q == 3'd0) ? 7'd1 : ((7'(nch_q) > 7'(MAX_CHANNELS)) ? 7'(MAX_CHANNELS)
                                                                   : 7'(nch_q));
    nk7 = (nk_q == 4'd0) ? 7'd1 : ((7'(nk_q) > 7'(MAX_FILTERS)) ? 7'(MAX_FILTERS)
                                                               : 7'(nk_q));
    kw  = KBW'(kw4);
    kh  = KBW'(kh4);
    nch = CCW'(nch7);
    nk  = FCW'(nk7);
    if (pad_q == cba_pkg::PAD_SAME) begin
      padw = CW'(kw4 >> 1);
      padh = CW'(kh4 >> 1);
    end else if (pad_q == cba_pkg::PAD_FULL) begin
      padw = CW'(kw4 - 4'd1);
      padh = CW'(kh4 - 4'd1);
    end else begin
      padw = '0;
      padh = '0;
    end
    pw = iw + (padw << 1);
    ph = ih + (padh << 1);
  end

  // input side
  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  logic [CW-1:0]  row_q, col_q, rowp_q, colp_q;
  logic [CCW-1:0] cc_q;
  logic [CHW-1:0] ch_q, ch_sel;
  logic signed [15:0] pix_q;
  logic border;
  logic [LAW-1:0] laddr_q, clr_q;

  assign ch_sel = (cc_q < nch) ? CHW'(cc_q) : '0;
  assign border = (row_q < padh) || (row_q >= padh + ih) ||
                  (col_q < padw) || (col_q >= padw + iw);

  // weight and bias stores
  logic           w_we;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [15:0]    w_rdata;
  logic signed [15:0] bias_q [MAX_FILTERS];

  assign w_we = in_acc && (in_word_i.operation == cba_pkg::OP_WEIGHT) &&
                (32'(in_word_i.filter_index) < 32'(MAX_FILTERS)) &&
                (32'(in_word_i.channel_index) < 32'(MAX_CHANNELS)) &&
                (32'(in_word_i.tap_row) < 32'(MAX_KERNEL)) &&
                (32'(in_word_i.tap_col) < 32'(MAX_KERNEL));
  assign w_waddr = WAW'(32'(in_word_i.filter_index) * N +
                        (32'(in_word_i.tap_row) * MAX_KERNEL + 32'(in_word_i.tap_col))
                        * MAX_CHANNELS + 32'(in_word_i.channel_index));

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_word_i.operation == cba_pkg::OP_BIAS) &&
        (32'(in_word_i.filter_index) < 32'(MAX_FILTERS))) begin
      bias_q[FW'(in_word_i.filter_index)] <= in_word_i.sample;
    end
  end

  cba_ram #(.WIDTH(16), .DEPTH(WD)) u_wram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (in_word_i.sample),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  // line store: one word holds the buffered rows of one column and channel
  logic             l_we;
  logic [LAW-1:0]   l_waddr, l_raddr;
  logic [LR*16-1:0] l_wdata, l_rdata, l_new;

  always_comb begin
    for (int r = 0; r < LR; r++) begin
      if (KBW'(r + 2) < kh && r + 1 < LR) begin
        l_new[r*16 +: 16] = l_rdata[(r+1)*16 +: 16];
      end else if (KBW'(r + 2) == kh) begin
        l_new[r*16 +: 16] = pix_q;
      end else begin
        l_new[r*16 +: 16] = l_rdata[r*16 +: 16];
      end
    end
  end

  assign l_raddr = LAW'(32'(col_q) * MAX_CHANNELS + 32'(ch_sel));
  assign l_we    = (state_q == ST_CLR) || (state_q == ST_LRD);
  assign l_waddr = (state_q == ST_CLR) ? clr_q : laddr_q;
  assign l_wdata = (state_q == ST_CLR) ? '0 : l_new;

  cba_ram #(.WIDTH(LR * 16), .DEPTH(LD)) u_lram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  // window ring
  logic signed [15:0] head;

  cba_window #(.MAX_KERNEL(MAX_KERNEL), .MAX_CHANNELS(MAX_CHANNELS)) u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rot_i  (state_q == ST_MAC),
    .upd_i  (state_q == ST_LRD),
    .ch_i   (ch_q),
    .kw_i   (kw),
    .kh_i   (kh),
    .line_i (l_rdata),
    .pix_i  (pix_q),
    .head_o (head)
  );

  // MAC sequencing
  logic [SW-1:0]  s_q;
  logic [KBW-1:0] tr_q, tc_q;
  logic [CHW-1:0] tk_q;
  logic [FW-1:0]  f_q;
  logic           v1_q, v2_q, m1_q;
  logic signed [15:0] x1_q;
  logic signed [31:0] p_q;
  logic signed [AW-1:0] acc_q, rnd, sh;
  logic signed [15:0] res_q, sat_v;
  logic [8:0] orow_q, ocol_q;
  logic       last_f;
  logic       out_free;

  assign w_raddr = WAW'(32'(f_q) * N + 32'(s_q));
  assign last_f  = (FCW'(f_q) + FCW'(1) == nk);
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    rnd = acc_q + AW'(8192);
    sh  = rnd >>> 14;
    if (act_q == cba_pkg::ACT_RELU && sh < 0) begin
      sh = '0;
    end
    if (sh > SAT_HI) begin
      sat_v = 16'sh7fff;
    end else if (sh < SAT_LO) begin
      sat_v = 16'sh8000;
    end else begin
      sat_v = sh[15:0];
    end
  end

  function automatic logic signed [AW-1:0] bias_ext(input logic signed [15:0] b);
    return $signed({{(AW - 30){b[15]}}, b, 14'd0});
  endfunction

  // product and accumulate pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p_q <= m1_q ? (x1_q * $signed(w_rdata)) : 32'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      cc_q        <= '0;
      v1_q        <= 1'b0;
      s_q         <= '0;
      tr_q        <= '0;
      tc_q        <= '0;
      tk_q        <= '0;
      f_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      v1_q <= 1'b0;
      if (out_valid_o && !out_stall_i && state_q != ST_EMIT) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + LAW'(1);
          if (clr_q == LAW'(LD - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && in_word_i.operation == cba_pkg::OP_PIXEL) begin
            state_q <= ST_LRD;
          end
        end
        ST_LRD: begin
          if (CCW'(ch_q) + CCW'(1) < nch) begin
            cc_q    <= CCW'(ch_q) + CCW'(1);
            state_q <= ST_IDLE;
          end else begin
            cc_q <= '0;
            if (colp_q + CW'(1) >= pw) begin
              col_q <= '0;
              row_q <= (rowp_q + CW'(1) >= ph) ? '0 : rowp_q + CW'(1);
            end else begin
              col_q <= colp_q + CW'(1);
            end
            if (rowp_q + CW'(1) >= CW'(kh) && colp_q + CW'(1) >= CW'(kw)) begin
              f_q     <= '0;
              s_q     <= '0;
              tr_q    <= '0;
              tc_q    <= '0;
              tk_q    <= '0;
              state_q <= ST_MAC;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_MAC: begin
          v1_q <= 1'b1;
          s_q  <= s_q + SW'(1);
          if (32'(tk_q) == MAX_CHANNELS - 1) begin
            tk_q <= '0;
            if (32'(tc_q) == MAX_KERNEL - 1) begin
              tc_q <= '0;
              tr_q <= tr_q + KBW'(1);
            end else begin
              tc_q <= tc_q + KBW'(1);
            end
          end else begin
            tk_q <= tk_q + CHW'(1);
          end
          if (s_q == SW'(N - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1_q && !v2_q) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            if (last_f) begin
              state_q <= ST_IDLE;
            end else begin
              f_q     <= f_q + FW'(1);
              s_q     <= '0;
              tr_q    <= '0;
              tc_q    <= '0;
              tk_q    <= '0;
              state_q <= ST_MAC;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // a register write restarts the raster
      if (cfg_we) begin
        row_q <= '0;
        col_q <= '0;
        cc_q  <= '0;
      end
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (in_acc && in_word_i.operation == cba_pkg::OP_PIXEL) begin
      ch_q    <= ch_sel;
      rowp_q  <= row_q;
      colp_q  <= col_q;
      laddr_q <= l_raddr;
      pix_q   <= border ? 16'sd0 : in_word_i.sample;
    end
    if (state_q == ST_LRD) begin
      orow_q <= 9'(rowp_q + CW'(1) - CW'(kh));
      ocol_q <= 9'(colp_q + CW'(1) - CW'(kw));
      acc_q  <= bias_ext(bias_q[0]);
    end
    if (state_q == ST_MAC) begin
      x1_q <= head;
      m1_q <= (tr_q < kh) && (tc_q < kw) && (8'(tk_q) < 8'(nch));
    end
    if (v2_q) begin
      acc_q <= acc_q + AW'(p_q);
    end
    if (state_q == ST_DRAIN && !v1_q && !v2_q) begin
      res_q <= sat_v;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_word_o.out_filter <= 3'(f_q);
      out_word_o.out_row    <= orow_q;
      out_word_o.out_col    <= ocol_q;
      out_word_o.out_value  <= (act_q == cba_pkg::ACT_SIGMOID) ?
                               cba_pkg::sigmoid_q88(res_q) : res_q;
      out_word_o.last       <= last_f;
      if (!last_f) begin
        acc_q <= bias_ext(bias_q[f_q + FW'(1)]);
      end
    end
  end

  `CBA_ASSERT_IMP(a_emit_drained, state_q == ST_EMIT, !v1_q && !v2_q, "MAC pipeline busy at emit")
  `CBA_ASSERT_NXT(a_pixel_reads, in_acc && in_word_i.operation == cba_pkg::OP_PIXEL, state_q == ST_LRD, "pixel word did not start line read")
  `CBA_ASSERT_IMP(a_last_kernel, out_valid_o && out_word_o.last, (32'(out_word_o.out_filter) + 1) == 32'(nk), "last flag on wrong kernel")
  `CBA_ASSERT_IMP(a_mac_step, state_q == ST_MAC, 32'(s_q) < N, "tap step out of range")

endmodule
